// ===== src/sgr_pkg.sv =====
// Shared constants, types and helpers for the SGR text attribute engine.
`default_nettype none

package sgr_pkg;

    localparam int unsigned CodeW = 15;
    localparam int unsigned AttrW = 8;

    localparam logic [AttrW-1:0] DefaultAttrRst = 8'h07;

    // Nibble masks: intensity=8, red=4, green=2, blue=1 in each nibble
    localparam logic [AttrW-1:0] FgI   = 8'h08;
    localparam logic [AttrW-1:0] FgRgb = 8'h07;
    localparam logic [AttrW-1:0] FgAll = 8'h0F;
    localparam logic [AttrW-1:0] BgI   = 8'h80;
    localparam logic [AttrW-1:0] BgRgb = 8'h70;
    localparam logic [AttrW-1:0] BgAll = 8'hF0;

    localparam logic [CodeW-1:0] SgrReset      = 15'd0;
    localparam logic [CodeW-1:0] SgrBold       = 15'd1;
    localparam logic [CodeW-1:0] SgrReverse    = 15'd7;
    localparam logic [CodeW-1:0] SgrNormal     = 15'd22;
    localparam logic [CodeW-1:0] SgrNoReverse  = 15'd27;
    localparam logic [CodeW-1:0] SgrFgBase     = 15'd30;
    localparam logic [CodeW-1:0] SgrFgExt      = 15'd38;
    localparam logic [CodeW-1:0] SgrFgDefault  = 15'd39;
    localparam logic [CodeW-1:0] SgrBgBase     = 15'd40;
    localparam logic [CodeW-1:0] SgrBgExt      = 15'd48;
    localparam logic [CodeW-1:0] SgrBgDefault  = 15'd49;
    localparam logic [CodeW-1:0] SgrFgBrtLo    = 15'd90;
    localparam logic [CodeW-1:0] SgrFgBrtHi    = 15'd97;
    localparam logic [CodeW-1:0] SgrBgBrtLo    = 15'd100;
    localparam logic [CodeW-1:0] SgrBgBrtHi    = 15'd107;
    localparam logic [CodeW-1:0] SgrRevShift   = 15'd10;
    localparam logic [CodeW-1:0] SgrBrtShift   = 15'd60;

    // Working copy of the attribute state carried between items
    typedef struct packed {
        logic [AttrW-1:0] attr;
        logic             reverse;
        logic             abort;
    } t_sgr_state;

    function automatic logic in_range(input logic [CodeW-1:0] p,
                                      input logic [CodeW-1:0] lo,
                                      input logic [CodeW-1:0] hi);
        return (p >= lo) && (p <= hi);
    endfunction

    // SGR colour index red=1,green=2,blue=4 to attribute R=4,G=2,B=1
    function automatic logic [2:0] colour_bits(input logic [CodeW-1:0] p,
                                               input logic [CodeW-1:0] base);
        logic [CodeW-1:0] c;
        c = p - base;
        return {c[0], c[1], c[2]};
    endfunction

endpackage

`default_nettype wire

// ===== src/sgr_code_if.sv =====
// Input channel: one SGR parameter per item with sequence marks.
`default_nettype none

interface sgr_code_if;
    logic                        valid;
    logic                        ready;
    logic [sgr_pkg::CodeW-1:0]   sgr_code;
    logic                        first_code;
    logic                        last_code;

    modport source (output valid, output sgr_code, output first_code,
                    output last_code, input ready);
    modport sink   (input valid, input sgr_code, input first_code,
                    input last_code, output ready);
endinterface

`default_nettype wire

// ===== src/sgr_attr_if.sv =====
// Output channel: committed attribute reported at the end of a sequence.
`default_nettype none

interface sgr_attr_if;
    logic                        valid;
    logic                        ready;
    logic [sgr_pkg::AttrW-1:0]   attribute;
    logic                        reverse_on;
    logic                        dropped;

    modport source (output valid, output attribute, output reverse_on,
                    output dropped, input ready);
    modport sink   (input valid, input attribute, input reverse_on,
                    input dropped, output ready);
endinterface

`default_nettype wire

// ===== src/sgr_decode.sv =====
// Combinational decode of one SGR parameter against the working state.
`default_nettype none

module sgr_decode (
    input  wire logic [sgr_pkg::CodeW-1:0] i_code,
    input  wire logic [sgr_pkg::AttrW-1:0] i_default,
    input  wire sgr_pkg::t_sgr_state       i_state,
    output sgr_pkg::t_sgr_state            o_state
);

    logic [sgr_pkg::CodeW-1:0] p_rev;
    logic [sgr_pkg::CodeW-1:0] p_fin;
    logic [sgr_pkg::AttrW-1:0] a;
    logic                      rev;
    logic                      abt;

    always_comb begin
        // reverse video swaps the fg and bg code ranges
        p_rev = i_code;
        if (i_state.reverse) begin
            if (sgr_pkg::in_range(i_code, sgr_pkg::SgrFgBase, sgr_pkg::SgrFgDefault) ||
                sgr_pkg::in_range(i_code, sgr_pkg::SgrFgBrtLo, sgr_pkg::SgrFgBrtHi)) begin
                p_rev = i_code + sgr_pkg::SgrRevShift;
            end else if (
                sgr_pkg::in_range(i_code, sgr_pkg::SgrBgBase, sgr_pkg::SgrBgDefault) ||
                sgr_pkg::in_range(i_code, sgr_pkg::SgrBgBrtLo, sgr_pkg::SgrBgBrtHi)) begin
                p_rev = i_code - sgr_pkg::SgrRevShift;
            end
        end

        a     = i_state.attr;
        p_fin = p_rev;
        if (sgr_pkg::in_range(p_rev, sgr_pkg::SgrFgBase, sgr_pkg::SgrFgDefault)) begin
            a = a & ~sgr_pkg::FgAll;
        end else if (sgr_pkg::in_range(p_rev, sgr_pkg::SgrBgBase, sgr_pkg::SgrBgDefault)) begin
            a = a & ~sgr_pkg::BgAll;
        end else if (sgr_pkg::in_range(p_rev, sgr_pkg::SgrFgBrtLo, sgr_pkg::SgrFgBrtHi)) begin
            a     = (a | sgr_pkg::FgI) & ~sgr_pkg::FgRgb;
            p_fin = p_rev - sgr_pkg::SgrBrtShift;
        end else if (sgr_pkg::in_range(p_rev, sgr_pkg::SgrBgBrtLo, sgr_pkg::SgrBgBrtHi)) begin
            a     = (a | sgr_pkg::BgI) & ~sgr_pkg::BgRgb;
            p_fin = p_rev - sgr_pkg::SgrBrtShift;
        end

        rev = i_state.reverse;
        abt = 1'b0;
        if (p_fin == sgr_pkg::SgrReset) begin
            a   = i_default;
            rev = 1'b0;
        end else if (p_fin == sgr_pkg::SgrBold) begin
            a = a | sgr_pkg::FgI;
        end else if (p_fin == sgr_pkg::SgrNormal) begin
            a = a & ~sgr_pkg::FgI;
        end else if (p_fin == sgr_pkg::SgrReverse) begin
            rev = 1'b1;
            a   = {a[3:0], a[7:4]};
        end else if (p_fin == sgr_pkg::SgrNoReverse) begin
            rev = 1'b0;
            a   = {a[3:0], a[7:4]};
        end else if (p_fin > sgr_pkg::SgrFgBase && p_fin < sgr_pkg::SgrFgExt) begin
            a = a | {5'd0, sgr_pkg::colour_bits(p_fin, sgr_pkg::SgrFgBase)};
        end else if (p_fin > sgr_pkg::SgrBgBase && p_fin < sgr_pkg::SgrBgExt) begin
            a = a | {1'b0, sgr_pkg::colour_bits(p_fin, sgr_pkg::SgrBgBase), 4'd0};
        end else if (p_fin == sgr_pkg::SgrFgDefault) begin
            a = a | (i_default & sgr_pkg::FgAll);
        end else if (p_fin == sgr_pkg::SgrBgDefault) begin
            a = a | (i_default & sgr_pkg::BgAll);
        end else if (p_fin == sgr_pkg::SgrFgExt || p_fin == sgr_pkg::SgrBgExt) begin
            abt = 1'b1;
        end

        // an aborting code leaves the working attribute alone
        o_state.attr    = abt ? i_state.attr : a;
        o_state.reverse = rev;
        o_state.abort   = abt;
    end

endmodule

`default_nettype wire

// ===== src/sgr_text_attribute_engine.sv =====
// Top level: SGR parameter stream to committed console colour attribute.
// A last-marked item shows its result on the output in the cycle after acceptance.
// Throughput: one item per cycle unless the output stalls; the working-state update is a
// single decode between the state register and the result register.
// Reset (synchronous, active low): attribute and default 0x07, reverse off,
// no abort pending, output empty.
`default_nettype none

module sgr_text_attribute_engine (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [sgr_pkg::AttrW-1:0] i_cfg_wdata,
    sgr_code_if.sink                       i_code,
    sgr_attr_if.source                     o_attr
);

    logic [sgr_pkg::AttrW-1:0] r_default;
    logic [sgr_pkg::AttrW-1:0] r_comm_attr;
    logic                      r_comm_rev;
    sgr_pkg::t_sgr_state       r_work;
    logic                      r_out_valid;
    logic [sgr_pkg::AttrW-1:0] r_out_attr;
    logic                      r_out_rev;
    logic                      r_out_drop;

    sgr_pkg::t_sgr_state       start_st;
    sgr_pkg::t_sgr_state       dec_st;
    sgr_pkg::t_sgr_state       n_work;
    logic [sgr_pkg::AttrW-1:0] n_comm_attr;
    logic                      n_comm_rev;
    logic                      accept;

    // output register frees while it is being taken
    assign i_code.ready = !r_out_valid || o_attr.ready;
    assign accept       = i_code.valid && i_code.ready;

    always_comb begin
        start_st = r_work;
        if (i_code.first_code) begin
            start_st.attr    = r_comm_attr;
            start_st.reverse = r_comm_rev;
            start_st.abort   = 1'b0;
        end
    end

    sgr_decode u_decode (
        .i_code    (i_code.sgr_code),
        .i_default (r_default),
        .i_state   (start_st),
        .o_state   (dec_st)
    );

    always_comb begin
        n_work      = start_st.abort ? start_st : dec_st;
        n_comm_attr = r_comm_attr;
        n_comm_rev  = r_comm_rev;
        if (i_code.last_code) begin
            if (!n_work.abort) begin
                n_comm_attr = n_work.attr;
                n_comm_rev  = n_work.reverse;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default    <= sgr_pkg::DefaultAttrRst;
            r_comm_attr  <= sgr_pkg::DefaultAttrRst;
            r_comm_rev   <= 1'b0;
            r_work.attr    <= sgr_pkg::DefaultAttrRst;
            r_work.reverse <= 1'b0;
            r_work.abort   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_default <= i_cfg_wdata;
            end
            if (accept && i_code.last_code) begin
                r_out_valid <= 1'b1;
            end else if (o_attr.ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                if (i_code.last_code) begin
                    r_comm_attr    <= n_comm_attr;
                    r_comm_rev     <= n_comm_rev;
                    r_work.attr    <= n_comm_attr;
                    r_work.reverse <= n_comm_rev;
                    r_work.abort   <= 1'b0;
                end else begin
                    r_work <= n_work;
                end
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept && i_code.last_code) begin
            r_out_attr <= n_comm_attr;
            r_out_rev  <= n_comm_rev;
            r_out_drop <= n_work.abort;
        end
    end

    assign o_attr.valid      = r_out_valid;
    assign o_attr.attribute  = r_out_attr;
    assign o_attr.reverse_on = r_out_rev;
    assign o_attr.dropped    = r_out_drop;

endmodule

`default_nettype wire

// ===== tb/sgr_text_attribute_engine_tb.sv =====
// Self-checking testbench for the SGR text attribute engine: directed and random sequences.
`timescale 1ns / 100ps

module sgr_text_attribute_engine_tb;

    typedef logic [sgr_pkg::CodeW-1:0] t_code;
    typedef logic [sgr_pkg::AttrW-1:0] t_attr;

    typedef struct {
        t_code code;
        logic  first;
        logic  last;
        bit    pinned;
        t_attr pin_attr;
        logic  pin_rev;
        logic  pin_drop;
    } t_sgr_item;

    typedef struct packed {
        t_attr attribute;
        logic  reverse_on;
        logic  dropped;
    } t_attr_report;

    typedef enum int {SeqClean, SeqNoFirst, SeqRestart} t_seq_shape;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_cfg_we;
    t_attr i_cfg_wdata;

    sgr_code_if code_bus ();
    sgr_attr_if attr_bus ();

    sgr_text_attribute_engine DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_code      (code_bus),
        .o_attr      (attr_bus)
    );

    // Attribute state mirror
    t_attr default_attr;
    t_attr shown_attr;
    logic  shown_rev;
    t_attr edit_attr;
    logic  edit_rev;
    logic  edit_dropped;

    t_sgr_item    offered_q[$];
    t_attr_report attr_reports_due[$];
    t_sgr_item    directed_rows[$];

    int         mismatches = 0;
    int         quiet_cycles = 0;
    int         hold_requests = 0;
    int         seq_left = 0;
    int         seq_pos = 0;
    t_seq_shape seq_shape = SeqClean;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Decode one parameter against the edit copy
    function automatic void apply_param(input t_code code);
        t_code      p;
        t_attr      a;
        logic [2:0] c;
        p = code;
        a = edit_attr;
        if (edit_rev) begin
            if ((p >= sgr_pkg::SgrFgBase && p <= sgr_pkg::SgrFgDefault) ||
                (p >= sgr_pkg::SgrFgBrtLo && p <= sgr_pkg::SgrFgBrtHi))
                p = p + sgr_pkg::SgrRevShift;
            else if ((p >= sgr_pkg::SgrBgBase && p <= sgr_pkg::SgrBgDefault) ||
                     (p >= sgr_pkg::SgrBgBrtLo && p <= sgr_pkg::SgrBgBrtHi))
                p = p - sgr_pkg::SgrRevShift;
        end
        if (p >= sgr_pkg::SgrFgBase && p <= sgr_pkg::SgrFgDefault) begin
            a = a & ~sgr_pkg::FgAll;
        end else if (p >= sgr_pkg::SgrBgBase && p <= sgr_pkg::SgrBgDefault) begin
            a = a & ~sgr_pkg::BgAll;
        end else if (p >= sgr_pkg::SgrFgBrtLo && p <= sgr_pkg::SgrFgBrtHi) begin
            a = (a | sgr_pkg::FgI) & ~sgr_pkg::FgRgb;
            p = p - sgr_pkg::SgrBrtShift;
        end else if (p >= sgr_pkg::SgrBgBrtLo && p <= sgr_pkg::SgrBgBrtHi) begin
            a = (a | sgr_pkg::BgI) & ~sgr_pkg::BgRgb;
            p = p - sgr_pkg::SgrBrtShift;
        end

        if (p == sgr_pkg::SgrReset) begin
            a = default_attr;
            edit_rev = 1'b0;
        end else if (p == sgr_pkg::SgrBold) begin
            a = a | sgr_pkg::FgI;
        end else if (p == sgr_pkg::SgrNormal) begin
            a = a & ~sgr_pkg::FgI;
        end else if (p == sgr_pkg::SgrReverse) begin
            edit_rev = 1'b1;
            a = {a[3:0], a[7:4]};
        end else if (p == sgr_pkg::SgrNoReverse) begin
            edit_rev = 1'b0;
            a = {a[3:0], a[7:4]};
        end else if (p > sgr_pkg::SgrFgBase && p < sgr_pkg::SgrFgExt) begin
            // colour index red=1 lands on attribute bit 2
            c = 3'(p - sgr_pkg::SgrFgBase);
            a = a | {5'b0, c[0], c[1], c[2]};
        end else if (p > sgr_pkg::SgrBgBase && p < sgr_pkg::SgrBgExt) begin
            c = 3'(p - sgr_pkg::SgrBgBase);
            a = a | {1'b0, c[0], c[1], c[2], 4'b0};
        end else if (p == sgr_pkg::SgrFgDefault) begin
            a = a | (default_attr & sgr_pkg::FgAll);
        end else if (p == sgr_pkg::SgrBgDefault) begin
            a = a | (default_attr & sgr_pkg::BgAll);
        end else if (p == sgr_pkg::SgrFgExt || p == sgr_pkg::SgrBgExt) begin
            edit_dropped = 1'b1;
        end
        if (!edit_dropped)
            edit_attr = a;
    endfunction

    function automatic bit step_sequence(input t_code code, input logic first,
                                         input logic last, output t_attr_report rep);
        if (first) begin
            edit_attr    = shown_attr;
            edit_rev     = shown_rev;
            edit_dropped = 1'b0;
        end
        if (!edit_dropped)
            apply_param(code);
        rep = '0;
        if (!last)
            return 1'b0;
        rep.dropped = edit_dropped;
        if (!edit_dropped) begin
            shown_attr = edit_attr;
            shown_rev  = edit_rev;
        end
        edit_attr      = shown_attr;
        edit_rev       = shown_rev;
        edit_dropped   = 1'b0;
        rep.attribute  = shown_attr;
        rep.reverse_on = shown_rev;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_sgr_item    offer;
        t_attr_report rep;
        t_attr_report due;
        if (!i_rst_n) begin
            default_attr = sgr_pkg::DefaultAttrRst;
            shown_attr   = sgr_pkg::DefaultAttrRst;
            shown_rev    = 1'b0;
            edit_attr    = sgr_pkg::DefaultAttrRst;
            edit_rev     = 1'b0;
            edit_dropped = 1'b0;
        end else begin
            if (i_cfg_we)
                default_attr = i_cfg_wdata;
            if (code_bus.valid && code_bus.ready) begin
                offer = offered_q.pop_front();
                if (step_sequence(code_bus.sgr_code, code_bus.first_code,
                                  code_bus.last_code, rep)) begin
                    if (offer.pinned)
                        rep = '{offer.pin_attr, offer.pin_rev, offer.pin_drop};
                    attr_reports_due.push_back(rep);
                end
            end
            if (attr_bus.valid && attr_bus.ready) begin
                if (attr_reports_due.size() == 0) begin
                    $error("attribute report with none outstanding: attr %h", attr_bus.attribute);
                    mismatches++;
                end else begin
                    due = attr_reports_due.pop_front();
                    if (attr_bus.attribute !== due.attribute) begin
                        $error("attribute: expected %h, got %h", due.attribute,
                               attr_bus.attribute);
                        mismatches++;
                    end
                    if (attr_bus.reverse_on !== due.reverse_on) begin
                        $error("reverse_on: expected %b, got %b", due.reverse_on,
                               attr_bus.reverse_on);
                        mismatches++;
                    end
                    if (attr_bus.dropped !== due.dropped) begin
                        $error("dropped: expected %b, got %b", due.dropped, attr_bus.dropped);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Cycles with no traffic at all end the run
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (code_bus.valid && code_bus.ready) ||
            (attr_bus.valid && attr_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 2000) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: stall density changes run by run; long hold on request
    initial begin : receiver
        int run_left;
        int stall_pct;
        int hold_left;
        int holds_done;
        run_left   = 0;
        stall_pct  = 0;
        hold_left  = 0;
        holds_done = 0;
        attr_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done++;
                hold_left = $urandom_range(60, 120);
            end
            if (run_left == 0) begin
                run_left = $urandom_range(5, 60);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 75;
                endcase
            end
            run_left--;
            if (hold_left > 0) begin
                hold_left--;
                attr_bus.ready <= 1'b0;
            end else begin
                attr_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    function automatic void add_row(input t_code code, input logic first,
                                    input logic last, input bit pinned,
                                    input t_attr attr, input logic rev,
                                    input logic drop);
        t_sgr_item it;
        it = '{code, first, last, pinned, attr, rev, drop};
        directed_rows.push_back(it);
    endfunction

    function automatic t_code pick_code();
        case ($urandom_range(0, 9))
            0: return t_code'($urandom_range(0, 32767));
            1: return t_code'($urandom_range(0, 127));
            2: return $urandom_range(0, 1) ? sgr_pkg::SgrReverse : sgr_pkg::SgrNoReverse;
            3: return $urandom_range(0, 1) ? sgr_pkg::SgrBold : sgr_pkg::SgrNormal;
            4: begin
                case ($urandom_range(0, 2))
                    0: return sgr_pkg::SgrReset;
                    1: return sgr_pkg::SgrFgDefault;
                    default: return sgr_pkg::SgrBgDefault;
                endcase
            end
            5, 6: return t_code'($urandom_range(30, 49));
            7, 8: return t_code'($urandom_range(90, 107));
            default: begin
                case ($urandom_range(0, 3))
                    0: return sgr_pkg::SgrFgExt;
                    1: return sgr_pkg::SgrBgExt;
                    default: return t_code'($urandom_range(0, 255));
                endcase
            end
        endcase
    endfunction

    // Mostly clean sequences; some lack the first mark, some restart midway
    function automatic t_sgr_item next_random_item();
        t_sgr_item it;
        int        r;
        if (seq_left == 0) begin
            seq_left = $urandom_range(1, 6);
            seq_pos  = 0;
            r = $urandom_range(0, 99);
            seq_shape = (r < 85) ? SeqClean : (r < 92) ? SeqNoFirst : SeqRestart;
        end
        it = '{pick_code(), 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0};
        it.first = (seq_pos == 0 && seq_shape != SeqNoFirst) ||
                   (seq_shape == SeqRestart && seq_pos > 0 && $urandom_range(0, 2) == 0);
        it.last  = (seq_left == 1);
        seq_pos++;
        seq_left--;
        return it;
    endfunction

    task automatic offer_item(input t_sgr_item it);
        offered_q.push_back(it);
        code_bus.valid      <= 1'b1;
        code_bus.sgr_code   <= it.code;
        code_bus.first_code <= it.first;
        code_bus.last_code  <= it.last;
        do @(posedge i_clk); while (!(code_bus.valid && code_bus.ready));
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            code_bus.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Sender quiet until every report is in, then the output register empties
    task automatic settle();
        code_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (attr_reports_due.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_default(input t_attr value);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(input int n);
        int sent;
        int burst;
        sent = 0;
        while (sent < n || seq_left != 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && (sent < n || seq_left != 0)) begin
                offer_item(next_random_item());
                sent++;
                burst--;
            end
            idle_gap(($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8));
        end
    endtask

    initial begin : stimulus
        t_sgr_item it;
        code_bus.valid      <= 1'b0;
        code_bus.sgr_code   <= '0;
        code_bus.first_code <= 1'b0;
        code_bus.last_code  <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_wdata         <= '0;
        i_rst_n             <= 1'b0;

        // Default attribute 0x07 after reset
        add_row(sgr_pkg::SgrReset,     1'b1, 1'b1, 1'b1, 8'h07, 1'b0, 1'b0);
        add_row(sgr_pkg::SgrBold,      1'b1, 1'b1, 1'b1, 8'h0F, 1'b0, 1'b0);
        add_row(sgr_pkg::SgrNormal,    1'b1, 1'b1, 1'b1, 8'h07, 1'b0, 1'b0);
        add_row(sgr_pkg::SgrFgExt,     1'b1, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        // codes after an abort ignored
        add_row(15'd31,                1'b0, 1'b1, 1'b1, 8'h07, 1'b0, 1'b1);
        add_row(sgr_pkg::SgrBgExt,     1'b1, 1'b1, 1'b1, 8'h07, 1'b0, 1'b1);
        add_row(sgr_pkg::SgrReverse,   1'b1, 1'b1, 1'b1, 8'h70, 1'b1, 1'b0);
        add_row(sgr_pkg::SgrNoReverse, 1'b1, 1'b1, 1'b1, 8'h07, 1'b0, 1'b0);
        // repeated swaps
        add_row(sgr_pkg::SgrReverse,   1'b1, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(sgr_pkg::SgrReverse,   1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(sgr_pkg::SgrNoReverse, 1'b0, 1'b1, 1'b0, '0, 1'b0, 1'b0);
        add_row(15'h7FFF,              1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0);
        // no first mark
        add_row(15'd34,                1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(sgr_pkg::SgrBgBrtHi,   1'b0, 1'b1, 1'b0, '0, 1'b0, 1'b0);
        // colours under reverse
        add_row(sgr_pkg::SgrReverse,   1'b1, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(15'd31,                1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(15'd42,                1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(15'd95,                1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(15'd101,               1'b0, 1'b1, 1'b0, '0, 1'b0, 1'b0);
        add_row(sgr_pkg::SgrFgBrtLo,   1'b1, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        // restart mid-sequence
        add_row(15'd44,                1'b1, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(sgr_pkg::SgrFgDefault, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(sgr_pkg::SgrBgDefault, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(sgr_pkg::SgrFgBrtHi,   1'b0, 1'b1, 1'b0, '0, 1'b0, 1'b0);
        add_row(sgr_pkg::SgrReset,     1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            offer_item(directed_rows[k]);
            idle_gap($urandom_range(0, 2));
        end
        settle();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_default(8'hFF);
                1: write_default(8'h00);
                default: write_default(t_attr'($urandom_range(0, 255)));
            endcase
            if (phase == 2) begin
                // output held off while one-item sequences keep coming
                hold_requests++;
                for (int k = 0; k < 40; k++) begin
                    it = next_random_item();
                    it.first = 1'b1;
                    it.last  = 1'b1;
                    seq_left = 0;
                    offer_item(it);
                end
            end
            run_random(182);
            settle();
        end

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
